// ===== rtl/erc_pkg.sv =====
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants of the EEPROM request chunker
// Field widths, device select codes and the chunk cursor record.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int ADDR_W     = 18;  // linear byte address
    localparam int LEN_W      = 13;  // byte count / chunk length
    localparam int OFF_W      = 16;  // offset inside one device
    localparam int BUF_W      = 12;  // offset into the caller's buffer
    localparam int BUS_W      = 8;   // bus address byte
    localparam int ROOM_W     = 17;  // bytes left in a device, up to 65536
    localparam int PG_W       = 10;  // bytes left in a page, up to 512
    localparam int DEV_W      = 2;   // device index
    localparam int RESULT_CAP = 34;  // most chunks one request may yield
    localparam int CNT_W      = 6;   // chunk counter, holds RESULT_CAP + 1

    localparam logic [BUS_W-1:0] BASE_RESET = 8'hA0;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Select code ORed into the bus address byte, by device index
    localparam logic [BUS_W-1:0] SEL_CODE [4] = '{8'h08, 8'h0A, 8'h0C, 8'h0E};

    // Position of the chunking cursor
    typedef struct packed {
        logic [DEV_W-1:0]  dev;        // device of the next chunk
        logic [OFF_W-1:0]  off;        // offset of the next chunk in its device
        logic [ROOM_W-1:0] dev_room;   // bytes up to the device end
        logic [PG_W-1:0]   page_room;  // bytes up to the page end (writes)
        logic [LEN_W-1:0]  remain;     // bytes of the request not yet chunked
        logic [LEN_W-1:0]  buf_off;    // bytes of the request already chunked
    } t_cursor;

endpackage

// ===== rtl/erc_req_if.sv =====
// ----------------------------------------------------------------------------
// erc_req_if: request channel of the EEPROM request chunker
// Valid/ready handshake carrying one read or write request.
// ----------------------------------------------------------------------------
interface erc_req_if;
    import erc_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  byte_count;

    modport source (output valid, output op, output start_address, output byte_count,
                    input ready);
    modport sink   (input valid, input op, input start_address, input byte_count,
                    output ready);
endinterface

// ===== rtl/erc_chunk_if.sv =====
// ----------------------------------------------------------------------------
// erc_chunk_if: chunk channel of the EEPROM request chunker
// Valid/ready handshake carrying one bus chunk or one error result.
// ----------------------------------------------------------------------------
interface erc_chunk_if;
    import erc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BUS_W-1:0]  bus_address;
    logic [OFF_W-1:0]  device_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [BUF_W-1:0]  buffer_offset;
    logic              is_last;
    logic              error;

    modport source (output valid, output bus_address, output device_offset,
                    output chunk_length, output buffer_offset, output is_last,
                    output error, input ready);
    modport sink   (input valid, input bus_address, input device_offset,
                    input chunk_length, input buffer_offset, input is_last,
                    input error, output ready);
endinterface

// ===== rtl/eeprom_request_chunker.sv =====
// ----------------------------------------------------------------------------
// eeprom_request_chunker: split linear EEPROM requests into bus chunks
// Maps a linear read/write request onto up to four devices and cuts it at
// device boundaries and, for writes, at page boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (op, start_address, byte_count). It is taken
//   only while the block is idle; one request is worked on at a time.
//   o_chunk carries the results: one chunk per piece of the request, the
//   final one marked is_last, or a single error result with is_last set.
//   i_cfg_we / i_cfg_wdata write the bus address base; write it only while
//   no request is in progress.
// Sequencing:
//   In the cycle after acceptance the request is checked and the cursor is
//   set up. Writes add a remainder pass (quotient, then remainder) when the
//   page size is not a power of two, and a counting pass over the chunks
//   when the parameters allow more than 34 chunks. Then the shared step unit
//   emits one chunk per cycle while o_chunk is free to take it; an invalid
//   request instead yields its single error result.
// Reset and stalls:
//   Reset returns to idle, drops any pending result and loads base 0xA0.
//   While a result waits with o_chunk.ready low, the output register holds and chunking waits.
// ----------------------------------------------------------------------------
module eeprom_request_chunker #(
    parameter int PAGE_BYTES   = 128,
    parameter int DEVICE_BYTES = 65536,
    parameter int NUM_DEVICES  = 4,
    parameter int TOP_LIMIT    = 262128,
    parameter int MAX_LEN      = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    erc_req_if.sink                     i_req,
    erc_chunk_if.source                 o_chunk,
    input  logic                        i_cfg_we,
    input  logic [erc_pkg::BUS_W-1:0]   i_cfg_wdata
);
    import erc_pkg::*;

    localparam int CAPACITY = NUM_DEVICES * DEVICE_BYTES;
    localparam int LIMIT    = (TOP_LIMIT < CAPACITY) ? TOP_LIMIT : CAPACITY;

    localparam logic [ADDR_W:0]   CAP_C     = (ADDR_W+1)'(CAPACITY);
    localparam logic [ADDR_W:0]   LIMIT_C   = (ADDR_W+1)'(LIMIT);
    localparam logic [LEN_W-1:0]  MAXLEN_C  = LEN_W'(MAX_LEN);
    localparam logic [PG_W-1:0]   PAGE_FULL = PG_W'(PAGE_BYTES);
    localparam logic [OFF_W-1:0]  PAGE_MASK = OFF_W'(PAGE_BYTES - 1);
    localparam bit                PAGE_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);

    // Reciprocal of the page size, exact for every 16-bit offset
    localparam int                 RECIP_SH = OFF_W + $clog2(PAGE_BYTES);
    localparam int                 RECIP_W  = OFF_W + 1;
    localparam longint             RECIP    = ((longint'(1) << RECIP_SH) +
                                               longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES);
    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);

    // Worst-case chunk counts; a counting pass is needed only beyond the cap
    localparam int PG_BOUND   = (MAX_LEN - 1) / PAGE_BYTES + 2;
    localparam int DV_BOUND   = (MAX_LEN - 1) / DEVICE_BYTES + 2;
    localparam int W_BOUND    = ((DEVICE_BYTES % PAGE_BYTES) == 0) ? PG_BOUND
                                                                   : PG_BOUND + DV_BOUND;
    localparam bit NEED_COUNT = (W_BOUND > RESULT_CAP);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_MOD   = 6'b000100,
        S_COUNT = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ERR   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic              r_op;
    logic [ADDR_W-1:0] r_start;
    logic [LEN_W-1:0]  r_count;
    t_cursor           r_cur, n_cur;
    logic [PG_W-1:0]   r_room0, n_room0;
    logic [OFF_W-1:0]  r_quot, n_quot;
    logic              r_mod_step, n_mod_step;
    logic [CNT_W-1:0]  r_nchunks, n_nchunks;
    logic [BUS_W-1:0]  r_base;

    logic              r_out_valid;
    logic [BUS_W-1:0]  r_out_bus;
    logic [OFF_W-1:0]  r_out_off;
    logic [LEN_W-1:0]  r_out_len;
    logic [BUF_W-1:0]  r_out_buf;
    logic              r_out_last;
    logic              r_out_err;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load_chunk;
    logic                     w_load_err;
    logic [ADDR_W:0]          w_end;
    logic                     w_bad;
    logic [DEV_W-1:0]         w_dev;
    logic [ADDR_W:0]          w_dev_base;
    logic [ADDR_W:0]          w_dev_end;
    logic [OFF_W-1:0]         w_off;
    logic [OFF_W-1:0]         w_off_low;
    t_cursor                  w_init;
    logic [OFF_W+RECIP_W-1:0] w_prod;
    logic [OFF_W+RECIP_W-1:0] w_prod_sh;
    logic [OFF_W-1:0]         w_quot;
    logic [OFF_W+PG_W-1:0]    w_qp;
    logic [PG_W-1:0]          w_mod;
    logic [LEN_W-1:0]         w_len;
    logic                     w_last;
    t_cursor                  w_next;
    t_state                   w_after_room;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_chunk.ready;

    // Locate the start address: device by compares against device edges
    always_comb begin
        w_dev      = '0;
        w_dev_base = '0;
        w_dev_end  = (ADDR_W+1)'(DEVICE_BYTES);
        for (int k = 1; k < 4; k++) begin
            if ((k < NUM_DEVICES) && ({1'b0, r_start} >= (ADDR_W+1)'(k * DEVICE_BYTES))) begin
                w_dev      = DEV_W'(k);
                w_dev_base = (ADDR_W+1)'(k * DEVICE_BYTES);
                w_dev_end  = (ADDR_W+1)'((k + 1) * DEVICE_BYTES);
            end
        end
        w_off     = OFF_W'({1'b0, r_start} - w_dev_base);
        w_off_low = w_off & PAGE_MASK;

        w_init.dev       = w_dev;
        w_init.off       = w_off;
        w_init.dev_room  = ROOM_W'(w_dev_end - {1'b0, r_start});
        w_init.page_room = r_room0;
        w_init.remain    = r_count;
        w_init.buf_off   = '0;
    end

    assign w_end = {1'b0, r_start} + (ADDR_W+1)'(r_count);
    assign w_bad = (r_count > MAXLEN_C) || ({1'b0, r_start} > LIMIT_C) ||
                   (w_end > LIMIT_C) || ({1'b0, r_start} >= CAP_C);

    // Offset modulo page size: quotient by reciprocal, remainder next cycle
    assign w_prod    = {{RECIP_W{1'b0}}, r_cur.off} * {{OFF_W{1'b0}}, RECIP_C};
    assign w_prod_sh = w_prod >> RECIP_SH;
    assign w_quot    = w_prod_sh[OFF_W-1:0];
    assign w_qp      = {{PG_W{1'b0}}, r_quot} * {{OFF_W{1'b0}}, PAGE_FULL};
    assign w_mod     = PG_W'(r_cur.off - w_qp[OFF_W-1:0]);

    assign w_after_room = NEED_COUNT ? S_COUNT : S_EMIT;

    erc_step #(
        .PAGE_BYTES   (PAGE_BYTES),
        .DEVICE_BYTES (DEVICE_BYTES)
    ) u_step (
        .i_cur   (r_cur),
        .i_write (r_op),
        .o_len   (w_len),
        .o_last  (w_last),
        .o_next  (w_next)
    );

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_room0      = r_room0;
        n_quot       = r_quot;
        n_mod_step   = r_mod_step;
        n_nchunks    = r_nchunks;
        w_load_chunk = 1'b0;
        w_load_err   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cur     = w_init;
                n_nchunks = '0;
                if (w_bad) begin
                    n_state = S_ERR;
                end else if (r_op == OP_READ) begin
                    n_state = S_EMIT;
                end else if (PAGE_POW2) begin
                    n_cur.page_room = PAGE_FULL - PG_W'(w_off_low);
                    n_room0         = PAGE_FULL - PG_W'(w_off_low);
                    n_state         = w_after_room;
                end else begin
                    n_mod_step = 1'b0;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (!r_mod_step) begin
                    n_quot     = w_quot;
                    n_mod_step = 1'b1;
                end else begin
                    n_cur.page_room = PAGE_FULL - w_mod;
                    n_room0         = PAGE_FULL - w_mod;
                    n_state         = w_after_room;
                end
            end
            S_COUNT: begin
                n_cur     = w_next;
                n_nchunks = r_nchunks + CNT_W'(1);
                if (r_nchunks == CNT_W'(RESULT_CAP)) begin
                    // drop the request: one chunk more than the cap
                    n_state = S_ERR;
                end else if (w_last) begin
                    n_cur   = w_init;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load_chunk = 1'b1;
                    n_cur        = w_next;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    w_load_err = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (w_load_chunk || w_load_err) begin
                r_out_valid <= 1'b1;
            end else if (o_chunk.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_req.op;
            r_start <= i_req.start_address;
            r_count <= i_req.byte_count;
        end
        r_cur      <= n_cur;
        r_room0    <= n_room0;
        r_quot     <= n_quot;
        r_mod_step <= n_mod_step;
        r_nchunks  <= n_nchunks;
        if (w_load_chunk) begin
            r_out_bus  <= r_base | SEL_CODE[r_cur.dev];
            r_out_off  <= r_cur.off;
            r_out_len  <= w_len;
            r_out_buf  <= r_cur.buf_off[BUF_W-1:0];
            r_out_last <= w_last;
            r_out_err  <= 1'b0;
        end else if (w_load_err) begin
            r_out_bus  <= '0;
            r_out_off  <= '0;
            r_out_len  <= '0;
            r_out_buf  <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_chunk.valid         = r_out_valid;
    assign o_chunk.bus_address   = r_out_bus;
    assign o_chunk.device_offset = r_out_off;
    assign o_chunk.chunk_length  = r_out_len;
    assign o_chunk.buffer_offset = r_out_buf;
    assign o_chunk.is_last       = r_out_last;
    assign o_chunk.error         = r_out_err;

endmodule

// ===== rtl/erc_step.sv =====
// ----------------------------------------------------------------------------
// erc_step: chunk step unit
// Cuts the next chunk at the cursor and advances the cursor past it.
// ----------------------------------------------------------------------------
module erc_step #(
    parameter int PAGE_BYTES   = 128,
    parameter int DEVICE_BYTES = 65536
) (
    input  erc_pkg::t_cursor             i_cur,
    input  logic                         i_write,
    output logic [erc_pkg::LEN_W-1:0]    o_len,
    output logic                         o_last,
    output erc_pkg::t_cursor             o_next
);
    import erc_pkg::*;

    localparam logic [ROOM_W-1:0] DEV_SIZE  = ROOM_W'(DEVICE_BYTES);
    localparam logic [PG_W-1:0]   PAGE_FULL = PG_W'(PAGE_BYTES);

    logic [ROOM_W-1:0] w_lim;
    logic [ROOM_W-1:0] w_dev_left;
    logic [PG_W-1:0]   w_page_left;

    always_comb begin
        // stop at the device end, the page end for writes, or the request end
        w_lim = i_cur.dev_room;
        if (i_write && (ROOM_W'(i_cur.page_room) < w_lim)) begin
            w_lim = ROOM_W'(i_cur.page_room);
        end
        if (ROOM_W'(i_cur.remain) < w_lim) begin
            o_len = i_cur.remain;
        end else begin
            o_len = w_lim[LEN_W-1:0];
        end
        o_last = (i_cur.remain == o_len);

        w_dev_left  = i_cur.dev_room - ROOM_W'(o_len);
        w_page_left = i_cur.page_room - PG_W'(o_len);

        o_next         = i_cur;
        o_next.remain  = i_cur.remain - o_len;
        o_next.buf_off = i_cur.buf_off + o_len;
        if (w_dev_left == '0) begin
            // advance to the next device, pages restart at its first byte
            o_next.dev       = i_cur.dev + DEV_W'(1);
            o_next.off       = '0;
            o_next.dev_room  = DEV_SIZE;
            o_next.page_room = PAGE_FULL;
        end else begin
            o_next.off      = i_cur.off + OFF_W'(o_len);
            o_next.dev_room = w_dev_left;
            if (i_write) begin
                o_next.page_room = (w_page_left == '0) ? PAGE_FULL : w_page_left;
            end
        end
    end

endmodule

// ===== tb/erc_chunk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erc_chunk_checker: chunk prediction and comparison for the request chunker
// Watches the request, chunk and bus base write ports. Every accepted
// request is split into the chunks it should yield. Every accepted chunk is
// compared field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module erc_chunk_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    erc_req_if                        i_req,
    erc_chunk_if                      i_chunk,
    input  logic                      i_cfg_we,
    input  logic [erc_pkg::BUS_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_chunks_seen
);
    import erc_pkg::*;

    localparam int unsigned PAGE_BYTES   = 128;
    localparam int unsigned DEVICE_BYTES = 65536;
    localparam int unsigned NUM_DEVICES  = 4;
    localparam int unsigned TOP_LIMIT    = 262128;
    localparam int unsigned MAX_LEN      = 4096;
    localparam int unsigned CAPACITY     = NUM_DEVICES * DEVICE_BYTES;
    localparam int unsigned USABLE_LIMIT = (TOP_LIMIT < CAPACITY) ? TOP_LIMIT : CAPACITY;

    typedef struct packed {
        logic [BUS_W-1:0] bus_address;
        logic [OFF_W-1:0] device_offset;
        logic [LEN_W-1:0] chunk_length;
        logic [BUF_W-1:0] buffer_offset;
        logic             is_last;
        logic             error;
    } t_chunk;

    t_chunk           expected_chunks[$];
    logic [BUS_W-1:0] bus_base;
    int               mismatches;
    int               chunks_seen;

    // Split one request into the chunks it owes, in address order
    function automatic void predict_chunks(input logic op, input logic [ADDR_W-1:0] start,
                                           input logic [LEN_W-1:0] count);
        int unsigned first;
        int unsigned len;
        int unsigned stop_at;
        int unsigned cur;
        int unsigned dev;
        int unsigned dbase;
        int unsigned page_end;
        int unsigned stop;
        logic        bad;
        t_chunk      piece;
        t_chunk      pieces[$];

        first   = 32'(start);
        len     = 32'(count);
        stop_at = first + len;
        bad = (len > MAX_LEN) || (first > USABLE_LIMIT) || (stop_at > USABLE_LIMIT) ||
              (first / DEVICE_BYTES >= NUM_DEVICES);

        if (!bad && len == 0) begin
            piece               = '0;
            piece.bus_address   = bus_base | SEL_CODE[(first / DEVICE_BYTES) % 4];
            piece.device_offset = OFF_W'(first % DEVICE_BYTES);
            piece.is_last       = 1'b1;
            pieces.push_back(piece);
        end else if (!bad) begin
            cur = first;
            while (cur < stop_at && !bad) begin
                dev   = cur / DEVICE_BYTES;
                dbase = dev * DEVICE_BYTES;
                stop  = dbase + DEVICE_BYTES;
                if (op == OP_WRITE) begin
                    page_end = dbase + ((cur - dbase) / PAGE_BYTES + 1) * PAGE_BYTES;
                    if (page_end < stop)
                        stop = page_end;
                end
                if (stop > stop_at)
                    stop = stop_at;
                if (pieces.size() >= RESULT_CAP) begin
                    bad = 1'b1;
                end else begin
                    piece.bus_address   = bus_base | SEL_CODE[dev % 4];
                    piece.device_offset = OFF_W'(cur - dbase);
                    piece.chunk_length  = LEN_W'(stop - cur);
                    piece.buffer_offset = BUF_W'(cur - first);
                    piece.is_last       = (stop == stop_at);
                    piece.error         = 1'b0;
                    pieces.push_back(piece);
                end
                cur = stop;
            end
        end

        if (bad) begin
            pieces.delete();
            piece         = '0;
            piece.is_last = 1'b1;
            piece.error   = 1'b1;
            pieces.push_back(piece);
        end
        foreach (pieces[i])
            expected_chunks.push_back(pieces[i]);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_chunk want;
        if (!i_rst_n) begin
            expected_chunks.delete();
            bus_base    = BASE_RESET;
            mismatches  = 0;
            chunks_seen = 0;
        end else begin
            if (i_cfg_we)
                bus_base = i_cfg_wdata;
            // Predict before popping, so a same-edge result finds its entry
            if (i_req.valid && i_req.ready)
                predict_chunks(i_req.op, i_req.start_address, i_req.byte_count);
            if (i_chunk.valid && i_chunk.ready) begin
                chunks_seen++;
                if (expected_chunks.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected chunk, expected none, actual bus %0h off %0d len %0d",
                             $time, i_chunk.bus_address, i_chunk.device_offset,
                             i_chunk.chunk_length);
                end else begin
                    want = expected_chunks.pop_front();
                    check_field("bus_address",   32'(want.bus_address),
                                32'(i_chunk.bus_address));
                    check_field("device_offset", 32'(want.device_offset),
                                32'(i_chunk.device_offset));
                    check_field("chunk_length",  32'(want.chunk_length),
                                32'(i_chunk.chunk_length));
                    check_field("buffer_offset", 32'(want.buffer_offset),
                                32'(i_chunk.buffer_offset));
                    check_field("is_last",       32'(want.is_last),
                                32'(i_chunk.is_last));
                    check_field("error",         32'(want.error),
                                32'(i_chunk.error));
                end
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= expected_chunks.size();
        o_chunks_seen <= chunks_seen;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: request chunker top-level test
// Drives directed edge-case requests and then random read/write requests
// under three handshake profiles and several bus base values; the chunk
// checker predicts and compares every chunk.
// ----------------------------------------------------------------------------
module testbench;
    import erc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 79;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [BUS_W-1:0] cfg_wdata;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               requests_sent;
    int               cycles;
    int               fail_count;
    int               pending;
    int               chunks_seen;

    erc_req_if   req_bus ();
    erc_chunk_if chunk_bus ();

    eeprom_request_chunker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_chunk     (chunk_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    erc_chunk_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_chunk       (chunk_bus),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_chunks_seen (chunks_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver side: stall at the current rate
    initial begin
        chunk_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            chunk_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Hold valid until the request is taken; between requests valid may drop at the tx_idle_pct rate
    task automatic send_request(input logic op, input int unsigned addr, input int unsigned cnt);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.op            <= op;
        req_bus.start_address <= ADDR_W'(addr);
        req_bus.byte_count    <= LEN_W'(cnt);
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_random_request;
        int unsigned sel;
        int unsigned addr;
        int unsigned cnt;
        logic        op;
        sel = $urandom_range(99);
        op  = 1'($urandom_range(1));
        if (sel < 30) begin
            // page-aligned writes with a small skew
            op   = OP_WRITE;
            addr = $urandom_range(3) * 65536 + $urandom_range(511) * 128 + $urandom_range(130);
            cnt  = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 300);
        end else if (sel < 50) begin
            addr = $urandom_range(1, 3) * 65536 - $urandom_range(1, 4096);
            cnt  = $urandom_range(1, 4096);
        end else if (sel < 65) begin
            addr = $urandom_range(262143);
            cnt  = $urandom_range(3000, 4096);
        end else if (sel < 75) begin
            addr = 262144 - $urandom_range(1, 4300);
            cnt  = $urandom_range(4200);
        end else if (sel < 85) begin
            addr = $urandom_range(262143);
            cnt  = $urandom_range(3);
        end else if (sel < 95) begin
            addr = $urandom_range(262143);
            cnt  = $urandom_range(4097, 8191);
        end else begin
            addr = $urandom_range(262143);
            cnt  = $urandom_range(8191);
        end
        send_request(op, addr, cnt);
    endtask

    task automatic wait_for_drain;
        req_bus.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bus_base(input logic [BUS_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        req_bus.valid         <= 1'b0;
        req_bus.op            <= OP_READ;
        req_bus.start_address <= '0;
        req_bus.byte_count    <= '0;
        tx_idle_pct   = 27;
        rx_idle_pct   = 68;
        requests_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed edge cases under the reset bus base
        send_request(OP_READ,  0,              0);
        send_request(OP_WRITE, 0,              0);
        send_request(OP_WRITE, 0,              1);
        send_request(OP_WRITE, 0,              128);
        send_request(OP_WRITE, 1,              128);
        send_request(OP_WRITE, 127,            2);
        send_request(OP_READ,  32'hFFFF,       2);
        send_request(OP_READ,  32'hF000,       4096);
        send_request(OP_WRITE, 32'hFF80,       128);
        send_request(OP_WRITE, 32'h1FF80,      4096);
        send_request(OP_WRITE, 64,             4096);
        send_request(OP_READ,  0,              4096);
        send_request(OP_READ,  32'h2FFFF,      300);
        send_request(OP_WRITE, 262128 - 4096,  4096);
        send_request(OP_READ,  262127,         1);
        send_request(OP_READ,  262128,         0);
        send_request(OP_READ,  262128,         1);
        send_request(OP_WRITE, 262129,         0);
        send_request(OP_READ,  32'h3FFFF,      0);
        send_request(OP_WRITE, 32'h3F000,      4096);
        send_request(OP_WRITE, 0,              4097);
        send_request(OP_READ,  32'h3FFFF,      8191);
        send_request(OP_READ,  32'h20000,      8191);
        wait_for_drain();

        set_bus_base(8'h00);
        repeat (PHASE_ITEMS) send_random_request();
        wait_for_drain();

        tx_idle_pct = 68;
        rx_idle_pct = 27;
        set_bus_base(8'hFF);
        repeat (PHASE_ITEMS) send_random_request();
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_bus_base(8'($urandom_range(1, 254)));
        repeat (PHASE_ITEMS - 1) send_random_request();
        wait_for_drain();

        $display("Covered %0d read/write requests: edge cases, page and device splits, errors",
                 requests_sent);
        $display("%0d chunks compared over three handshake profiles and four bus bases",
                 chunks_seen);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
